>>> design/sed_pkg.sv
// shared types, character codes and helpers for the string escape decoder
package sed_pkg;

	localparam int unsigned MAX_RES = 4;

	// configuration register indexes
	localparam logic CFG_QUOTE   = 1'b0;
	localparam logic CFG_UNICODE = 1'b1;

	// result error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_ESCAPE    = 3'd1;
	localparam logic [2:0] ERR_LEAD      = 3'd2;
	localparam logic [2:0] ERR_OCTAL     = 3'd3;
	localparam logic [2:0] ERR_HEX       = 3'd4;
	localparam logic [2:0] ERR_UNICODE   = 3'd5;
	localparam logic [2:0] ERR_CODEPOINT = 3'd6;
	localparam logic [2:0] ERR_UNTERM    = 3'd7;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_LC_V   = 8'h76;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_CASE   = 8'h20;

	// control characters produced by letter escapes
	localparam logic [7:0] CC_BEL = 8'h07;
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_HT  = 8'h09;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_VT  = 8'h0B;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_CR  = 8'h0D;

	localparam logic [31:0] ACC_SHIFT_MAX = 32'h0FFF_FFFF;
	localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;
	localparam logic [31:0] SURR_LO       = 32'h0000_D800;
	localparam logic [31:0] SURR_HI       = 32'h0000_DFFF;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic [2:0] err;
	} res_t;

	typedef struct packed {
		logic [2:0]           cnt;
		res_t [MAX_RES-1:0]   ent;
	} bundle_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]       cnt;
		logic [3:0][7:0]  bytes;
	} utf8_t;

	function automatic hex_t hex_digit(input logic [7:0] b);
		hex_t r;
		r = '0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			r.ok  = 1'b1;
			r.val = b[3:0];
		end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
			r.ok  = 1'b1;
			r.val = b[3:0] + 4'd9;
		end
		return r;
	endfunction

	function automatic logic cp_ok(input logic [31:0] cp);
		return (cp <= CP_MAX) && !(cp >= SURR_LO && cp <= SURR_HI);
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.cnt      = 3'd1;
			r.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			r.cnt      = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.cnt      = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.cnt      = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

>>> design/sed_core.sv
// escape state registers and the per-byte decode into a result bundle
module sed_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic [7:0]       quote_char,
	input  logic             allow_unicode,
	output sed_pkg::bundle_t bundle
);
	import sed_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_ESC, PH_HEX1, PH_HEX2, PH_OCT1, PH_OCT2,
		PH_USTART, PH_UBMP, PH_UBRACE
	} phase_t;

	phase_t      phase_q, phase_n, ph;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  dig_q, dig_n;
	logic [1:0]  lead_q, lead_n;
	logic        drop_q, drop_n;

	always_comb begin
		hex_t       h;
		utf8_t      u;
		bundle_t    main_b;
		res_t       zero_res;
		logic       pre;
		logic       fail_en;
		logic [2:0] fail_code;
		logic       emit_en;
		logic [7:0] emit_byte;
		logic       utf_en;
		logic       close_en;
		logic [2:0] close_err;

		h         = hex_digit(in_byte);
		u         = utf8_enc(acc_q[20:0]);
		main_b    = '0;
		zero_res  = '0;
		pre       = 1'b0;
		fail_en   = 1'b0;
		fail_code = ERR_NONE;
		emit_en   = 1'b0;
		emit_byte = in_byte;
		utf_en    = 1'b0;
		close_en  = 1'b0;
		close_err = ERR_NONE;
		phase_n   = phase_q;
		acc_n     = acc_q;
		dig_n     = dig_q;
		lead_n    = lead_q;
		drop_n    = drop_q;
		ph        = phase_q;

		if (drop_q) begin
			if (in_last) begin
				drop_n   = 1'b0;
				phase_n  = PH_IDLE;
				close_en = 1'b1;
			end
		end else begin
			// a lone \0 right before the quote ends early with a zero byte
			if (phase_q == PH_OCT1 && lead_q == 2'd0 && in_byte == quote_char) begin
				pre     = 1'b1;
				ph      = PH_IDLE;
				phase_n = PH_IDLE;
			end
			if (ph == PH_IDLE) begin
				if (in_last)
					close_en = 1'b1;
				else if (in_byte == CH_BSLASH)
					phase_n = PH_ESC;
				else
					emit_en = 1'b1;
			end else if (in_last) begin
				phase_n   = PH_IDLE;
				close_en  = 1'b1;
				close_err = ERR_UNTERM;
			end else begin
				case (ph)
					PH_ESC: begin
						phase_n = PH_IDLE;
						if ((in_byte | CH_CASE) >= CH_LC_A && (in_byte | CH_CASE) <= CH_LC_Z) begin
							emit_en = 1'b1;
							case (in_byte)
								CH_LC_A: emit_byte = CC_BEL;
								CH_LC_B: emit_byte = CC_BS;
								CH_LC_T: emit_byte = CC_HT;
								CH_LC_N: emit_byte = CC_LF;
								CH_LC_V: emit_byte = CC_VT;
								CH_LC_F: emit_byte = CC_FF;
								CH_LC_R: emit_byte = CC_CR;
								CH_LC_X: begin
									emit_en = 1'b0;
									phase_n = PH_HEX1;
								end
								CH_LC_U: begin
									emit_en = 1'b0;
									if (allow_unicode) begin
										phase_n = PH_USTART;
									end else begin
										fail_en   = 1'b1;
										fail_code = ERR_ESCAPE;
									end
								end
								default: begin
									emit_en   = 1'b0;
									fail_en   = 1'b1;
									fail_code = ERR_ESCAPE;
								end
							endcase
						end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
							if (in_byte > CH_THREE) begin
								fail_en   = 1'b1;
								fail_code = ERR_LEAD;
							end else begin
								lead_n  = in_byte[1:0];
								phase_n = PH_OCT1;
							end
						end else begin
							emit_en = 1'b1;
						end
					end
					PH_HEX1: begin
						if (!h.ok) begin
							fail_en   = 1'b1;
							fail_code = ERR_HEX;
						end else begin
							acc_n   = {28'd0, h.val};
							phase_n = PH_HEX2;
						end
					end
					PH_HEX2: begin
						if (!h.ok) begin
							fail_en   = 1'b1;
							fail_code = ERR_HEX;
						end else begin
							emit_en   = 1'b1;
							emit_byte = {acc_q[3:0], h.val};
							phase_n   = PH_IDLE;
						end
					end
					PH_OCT1: begin
						if (in_byte < CH_ZERO || in_byte > CH_SEVEN) begin
							fail_en   = 1'b1;
							fail_code = ERR_OCTAL;
						end else begin
							acc_n   = {27'd0, lead_q, in_byte[2:0]};
							phase_n = PH_OCT2;
						end
					end
					PH_OCT2: begin
						if (in_byte < CH_ZERO || in_byte > CH_SEVEN) begin
							fail_en   = 1'b1;
							fail_code = ERR_OCTAL;
						end else begin
							emit_en   = 1'b1;
							emit_byte = {acc_q[4:0], in_byte[2:0]};
							phase_n   = PH_IDLE;
						end
					end
					PH_USTART: begin
						acc_n = '0;
						dig_n = '0;
						if (in_byte == CH_LBRACE) begin
							phase_n = PH_UBRACE;
						end else if (!h.ok) begin
							fail_en   = 1'b1;
							fail_code = ERR_UNICODE;
						end else begin
							acc_n   = {28'd0, h.val};
							dig_n   = 3'd1;
							phase_n = PH_UBMP;
						end
					end
					PH_UBMP: begin
						if (!h.ok) begin
							fail_en   = 1'b1;
							fail_code = ERR_UNICODE;
						end else begin
							acc_n = {16'd0, acc_q[11:0], h.val};
							dig_n = dig_q + 3'd1;
							if (dig_n >= 3'd4) begin
								if (!cp_ok(acc_n)) begin
									fail_en   = 1'b1;
									fail_code = ERR_CODEPOINT;
								end else begin
									// encode the completed four-digit value
									u       = utf8_enc(acc_n[20:0]);
									utf_en  = 1'b1;
									phase_n = PH_IDLE;
								end
							end
						end
					end
					PH_UBRACE: begin
						if (h.ok) begin
							if (acc_q > ACC_SHIFT_MAX) begin
								fail_en   = 1'b1;
								fail_code = ERR_UNICODE;
							end else begin
								acc_n = {acc_q[27:0], h.val};
								dig_n = 3'd1;
							end
						end else if (dig_q == 3'd0) begin
							fail_en   = 1'b1;
							fail_code = ERR_UNICODE;
						end else if (!cp_ok(acc_q)) begin
							fail_en   = 1'b1;
							fail_code = ERR_CODEPOINT;
						end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
							utf_en = 1'b1;
							acc_n  = '0;
							dig_n  = '0;
						end else if (in_byte == CH_RBRACE) begin
							utf_en  = 1'b1;
							phase_n = PH_IDLE;
						end else begin
							fail_en   = 1'b1;
							fail_code = ERR_UNICODE;
						end
					end
					default: phase_n = PH_IDLE;
				endcase
			end
		end

		if (fail_en) begin
			main_b.cnt        = 3'd1;
			main_b.ent[0].err = fail_code;
			phase_n           = PH_IDLE;
			drop_n            = 1'b1;
		end else if (close_en) begin
			main_b.cnt         = 3'd1;
			main_b.ent[0].last = 1'b1;
			main_b.ent[0].err  = close_err;
		end else if (emit_en) begin
			main_b.cnt          = 3'd1;
			main_b.ent[0].data  = emit_byte;
			main_b.ent[0].valid = 1'b1;
		end else if (utf_en) begin
			main_b.cnt = u.cnt;
			for (int i = 0; i < MAX_RES; i++) begin
				main_b.ent[i].data  = u.bytes[i];
				main_b.ent[i].valid = (3'(i) < u.cnt);
			end
		end

		// the early zero byte goes ahead of whatever the byte itself gives
		zero_res.valid = 1'b1;
		bundle.cnt     = main_b.cnt + {2'd0, pre};
		bundle.ent[0]  = pre ? zero_res : main_b.ent[0];
		for (int i = 1; i < MAX_RES; i++)
			bundle.ent[i] = pre ? main_b.ent[i-1] : main_b.ent[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			dig_q   <= '0;
			lead_q  <= '0;
			drop_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			dig_q   <= dig_n;
			lead_q  <= lead_n;
			drop_q  <= drop_n;
		end
	end

endmodule

>>> design/sed_obuf.sv
// result register holding one item's results, handing out one per cycle while m_tready is high
module sed_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sed_pkg::bundle_t bundle,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,   // out_last
	output logic [3:0]       m_tuser    // out_valid, error_code[2:0]
);
	import sed_pkg::*;

	res_t [MAX_RES-1:0] ent_q;
	logic [1:0]         rd_q;
	logic [2:0]         rem_q;
	logic               pop;
	res_t               cur;

	assign cur      = ent_q[rd_q];
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = cur.data;
	assign m_tlast  = cur.last;
	assign m_tuser  = {cur.err, cur.valid};
	assign pop      = m_tvalid && m_tready;
	assign free     = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			rem_q <= '0;
		end else if (load) begin
			rd_q  <= '0;
			rem_q <= bundle.cnt;
		end else if (pop) begin
			rd_q  <= rd_q + 2'd1;
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ent_q <= bundle.ent;
	end

`ifndef ASSERT_OFF
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd4)
		else $error("result count above four");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> rem_q == 3'd1)
		else $error("closing result is not the final one of its item");

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cur.err != ERR_NONE |-> !cur.valid && rem_q == 3'd1 && rd_q == 2'd0)
		else $error("error result mixed with decoded bytes");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("results loaded over undelivered ones");
`endif

endmodule

>>> design/string_escape_decoder_utf8.sv
// top level of the string escape decoder with unicode escapes
// Usage:
//   s_* carries the body of a quoted literal, one byte per item, with the
//   closing quote marked by s_tlast. m_* carries results: m_tdata is the
//   decoded byte, m_tuser[0] says it is a real byte, m_tuser[3:1] holds the
//   error code and m_tlast marks the final result of the literal.
//   cfg_we/cfg_index/cfg_data write quote_char (index 0) and allow_unicode
//   (index 1); write only while no item is in flight.
// Timing:
//   an accepted byte sits in the input register, then its results (0 to 4)
//   load into the result register, which shows the first of them. The result
//   register drains one result per cycle while m_tready is high, and the
//   next byte with results waits in the input register until the last is taken;
//   bytes giving zero or one result go at one per cycle while m_tready is high.
// Reset:
//   arst_n clears the escape state, empties both registers and restores
//   quote_char to 0x22 and allow_unicode to 1.
//   when m_tready is low the result register holds and s_tready drops once
//   the input register has a byte waiting with results.
module string_escape_decoder_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // out_last
	output logic [3:0] m_tuser,   // out_valid, error_code[2:0]
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import sed_pkg::*;

	logic [7:0] byte_s1;
	logic       last_s1;
	logic       vld_s1;
	logic [7:0] quote_q;
	logic       allow_q;
	logic       adv;
	logic       free;
	bundle_t    bundle;

	// a byte with no results never waits for the result register
	assign adv      = vld_s1 && (bundle.cnt == 3'd0 || free);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 8'h22;
			allow_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUOTE:   quote_q <= cfg_data;
				CFG_UNICODE: allow_q <= cfg_data[0];
				default:     quote_q <= quote_q;
			endcase
		end
	end

	sed_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.in_byte       (byte_s1),
		.in_last       (last_s1),
		.quote_char    (quote_q),
		.allow_unicode (allow_q),
		.bundle        (bundle)
	);

	sed_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && bundle.cnt != 3'd0),
		.bundle   (bundle),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
